// File: sv/mck_pkg.sv
// Package for the Morse character keyer: Morse symbol table, lookup function,
// register indexes, FSM state type and controller/datapath signal bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

    localparam int unsigned CodeWidth = 8;
    localparam int unsigned DurWidth  = 10;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned ElemMax   = 5;
    localparam int unsigned CntWidth  = 3;
    localparam int unsigned SymCount  = 36;
    localparam int unsigned SymIdxW   = 6;

    localparam logic [CfgIdxW-1:0] CFG_DIT_ON   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DAH_ON   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_ELEM_GAP = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_CHAR_GAP = 2'd3;

    localparam logic [DurWidth-1:0] DIT_ON_RESET   = 10'd60;
    localparam logic [DurWidth-1:0] DAH_ON_RESET   = 10'd180;
    localparam logic [DurWidth-1:0] ELEM_GAP_RESET = 10'd60;
    localparam logic [DurWidth-1:0] CHAR_GAP_RESET = 10'd180;

    localparam logic [CodeWidth-1:0] CODE_HEX_MAX   = 8'h0F;
    localparam logic [CodeWidth-1:0] CODE_DIGIT_LO  = 8'h30;
    localparam logic [CodeWidth-1:0] CODE_DIGIT_HI  = 8'h39;
    localparam logic [CodeWidth-1:0] CODE_LETTER_LO = 8'h61;
    localparam logic [CodeWidth-1:0] CODE_LETTER_HI = 8'h7A;
    localparam logic [SymIdxW-1:0]   SYM_LETTER_A   = 6'd10;

    // bits 7..5 element count, bits 4..0 elements, first in bit 0, 1 = dah
    localparam logic [7:0] MORSE_TABLE [SymCount] = '{
        8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF,
        8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
        8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
        8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83
    };

    typedef struct packed {
        logic                hit;
        logic [CntWidth-1:0] count;
        logic [ElemMax-1:0]  bits;
    } t_sym;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ON,
        S_GAP,
        S_CHAR
    } t_state;

    typedef enum logic [1:0] {
        SEG_ELEMENT,
        SEG_ELEM_GAP,
        SEG_CHAR_GAP
    } t_seg;

    typedef struct packed {
        logic load;
        logic emit;
        logic shift;
        t_seg seg;
    } t_cmd;

    typedef struct packed {
        logic sym_hit;
        logic last_elem;
    } t_sts;

    function automatic t_sym mck_lookup(input logic [CodeWidth-1:0] code);
        t_sym                res;
        logic [SymIdxW-1:0]  idx;
        logic [CodeWidth-1:0] diff;
        logic [7:0]          entry;
        res  = '0;
        idx  = '0;
        diff = '0;
        if (code <= CODE_HEX_MAX) begin
            res.hit = 1'b1;
            idx     = SymIdxW'(code);
        end else if (code >= CODE_DIGIT_LO && code <= CODE_DIGIT_HI) begin
            res.hit = 1'b1;
            diff    = code - CODE_DIGIT_LO;
            idx     = SymIdxW'(diff);
        end else if (code >= CODE_LETTER_LO && code <= CODE_LETTER_HI) begin
            res.hit = 1'b1;
            diff    = code - CODE_LETTER_LO;
            idx     = SymIdxW'(diff) + SYM_LETTER_A;
        end
        entry     = MORSE_TABLE[idx];
        res.count = entry[7:5];
        res.bits  = entry[4:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/mck_char_if.sv
// Input channel of the Morse keyer: one character code per item.
// Depends on mck_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mck_char_if
    import mck_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CodeWidth-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// File: sv/mck_seg_if.sv
// Output channel of the Morse keyer: one timed key segment per item.
// Depends on mck_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mck_seg_if
    import mck_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                key_on;
    logic [DurWidth-1:0] duration;
    logic                run_last;

    modport source (output valid, output key_on, output duration, output run_last,
                    input ready);
    modport sink   (input valid, input key_on, input duration, input run_last,
                    output ready);
endinterface

`default_nettype wire

// File: sv/morse_character_keyer_core.sv
// Morse character keyer: one character code in, a run of timed key segments out.
// On acceptance the code is loaded; the on state then emits the first segment.
// Throughput: one segment per cycle while the output is not stalled; a character
// of n elements makes 2n+1 segments (3 to 11), one per controller state step.
// The next character is taken in the cycle its character gap goes out.
// Reset (i_rst_n, synchronous, low) idles the controller and loads default lengths.
`timescale 1ns / 1ps
`default_nettype none

module morse_character_keyer_core
    import mck_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [CfgIdxW-1:0]  i_cfg_idx,
    input  wire [DurWidth-1:0] i_cfg_data,
    mck_char_if.sink           i_char,
    mck_seg_if.source          o_seg
);

    t_cmd cmd;
    t_sts sts;

    mck_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_char.valid),
        .o_in_ready  (i_char.ready),
        .i_out_ready (o_seg.ready),
        .o_out_valid (o_seg.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mck_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_char_code (i_char.char_code),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_key_on    (o_seg.key_on),
        .o_duration  (o_seg.duration),
        .o_run_last  (o_seg.run_last)
    );

endmodule

`default_nettype wire

// File: sv/mck_ctrl.sv
// Keyer controller: walks a character through on / gap / character-gap states
// and owns the handshakes. Depends on mck_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mck_ctrl
    import mck_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  wire  i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   emit;
    logic   accept;

    // a segment may go out when the output register is empty or draining
    assign emit   = (r_state != S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sts.sym_hit) n_state = S_ON;
            end
            S_ON: begin
                if (emit) n_state = S_GAP;
            end
            S_GAP: begin
                if (emit) n_state = i_sts.last_elem ? S_CHAR : S_ON;
            end
            S_CHAR: begin
                if (emit) n_state = (accept && i_sts.sym_hit) ? S_ON : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.seg   = SEG_ELEMENT;
        o_cmd.shift = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_ON:   o_cmd.seg = SEG_ELEMENT;
            S_GAP: begin
                o_cmd.seg   = SEG_ELEM_GAP;
                o_cmd.shift = emit;
            end
            S_CHAR: begin
                o_cmd.seg  = SEG_CHAR_GAP;
                o_in_ready = emit;
            end
            default: o_in_ready = 1'b0;
        endcase
        o_cmd.load = accept;
        o_cmd.emit = emit;
    end

    assign n_out_valid = emit || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: sv/mck_datapath.sv
// Keyer datapath: length registers, element shift register and count,
// and the registered output segment. Depends on mck_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mck_datapath
    import mck_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CfgIdxW-1:0]    i_cfg_idx,
    input  wire [DurWidth-1:0]   i_cfg_data,
    input  wire [CodeWidth-1:0]  i_char_code,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_key_on,
    output logic [DurWidth-1:0]  o_duration,
    output logic                 o_run_last
);

    logic [DurWidth-1:0] r_dit_on, r_dah_on, r_elem_gap, r_char_gap;
    logic [ElemMax-1:0]  r_bits, n_bits;
    logic [CntWidth-1:0] r_cnt, n_cnt;
    logic                r_key_on, n_key_on;
    logic [DurWidth-1:0] r_duration, n_duration;
    logic                r_run_last, n_run_last;
    t_sym                sym;

    assign sym             = mck_lookup(i_char_code);
    assign o_sts.sym_hit   = sym.hit;
    assign o_sts.last_elem = (r_cnt == CntWidth'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit_on   <= DIT_ON_RESET;
            r_dah_on   <= DAH_ON_RESET;
            r_elem_gap <= ELEM_GAP_RESET;
            r_char_gap <= CHAR_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIT_ON:   r_dit_on   <= i_cfg_data;
                CFG_DAH_ON:   r_dah_on   <= i_cfg_data;
                CFG_ELEM_GAP: r_elem_gap <= i_cfg_data;
                CFG_CHAR_GAP: r_char_gap <= i_cfg_data;
                default:      r_dit_on   <= r_dit_on;
            endcase
        end
    end

    always_comb begin
        n_bits = r_bits;
        n_cnt  = r_cnt;
        if (i_cmd.load) begin
            n_bits = sym.bits;
            n_cnt  = sym.count;
        end else if (i_cmd.shift) begin
            n_bits = r_bits >> 1;
            n_cnt  = r_cnt - CntWidth'(1);
        end
    end

    always_comb begin
        n_key_on   = r_key_on;
        n_duration = r_duration;
        n_run_last = r_run_last;
        if (i_cmd.emit) begin
            case (i_cmd.seg)
                SEG_ELEMENT: begin
                    n_key_on   = 1'b1;
                    n_duration = r_bits[0] ? r_dah_on : r_dit_on;
                    n_run_last = 1'b0;
                end
                SEG_ELEM_GAP: begin
                    n_key_on   = 1'b0;
                    n_duration = r_elem_gap;
                    n_run_last = 1'b0;
                end
                default: begin
                    n_key_on   = 1'b0;
                    n_duration = r_char_gap;
                    n_run_last = 1'b1;
                end
            endcase
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_bits     <= n_bits;
        r_cnt      <= n_cnt;
        r_key_on   <= n_key_on;
        r_duration <= n_duration;
        r_run_last <= n_run_last;
    end

    assign o_key_on   = r_key_on;
    assign o_duration = r_duration;
    assign o_run_last = r_run_last;

endmodule

`default_nettype wire
